// ===== design/pfr_pkg.sv =====
`default_nettype none

package pfr_pkg;

    localparam int NUM_FRAMES_DEF = 256;
    localparam int AGE_BITS_DEF   = 16;

    // frame count is also capped by the 8-bit frame index
    localparam int ADDR_LIMIT     = 256;

    localparam int REQ_W          = 3;
    localparam int FRAME_W        = 8;
    localparam int HAND_W         = 9;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 9;

    localparam logic [REQ_W-1:0] REQ_TOUCH     = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FIND_FREE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_VICTIM    = 3'd2;
    localparam logic [REQ_W-1:0] REQ_MARK_OCC  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_MARK_FREE = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAMES_IN_USE = 2'd1;

    localparam logic [CFG_DATA_W-1:0] FRAMES_RESET = 9'd256;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [FRAME_W-1:0] frame_index;
    } t_req;

    typedef struct packed {
        logic [FRAME_W-1:0] result_frame;
        logic               found;
    } t_res;

endpackage

`default_nettype wire

// ===== design/page_frame_replacement_unit.sv =====
// Page frame replacement unit: frame table of free flags and use values
// (LRU ages or clock reference bits) held in a ring of NUM_FRAMES cells that
// rotates one position per cycle, while an item is in progress, past a single
// head controller. An item is accepted when start is high and busy low, and it
// normally takes one full rotation; the result strobe o_done and the drop of
// busy come in the same cycle, so the next item may be accepted there. A
// clock-mode victim scan that finds no clear bit on its first rotation takes
// a second one. There is no result backpressure: o_res is valid only in the
// o_done cycle. The configuration port is always ready; mode and frame count
// are sampled when an item is accepted.
`default_nettype none

module page_frame_replacement_unit #(
    parameter int NUM_FRAMES = pfr_pkg::NUM_FRAMES_DEF,
    parameter int AGE_BITS   = pfr_pkg::AGE_BITS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire pfr_pkg::t_req                   i_req,
    output logic                                 o_done,
    output pfr_pkg::t_res                        o_res,
    input  wire logic                            i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire logic [pfr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [pfr_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    logic                shift;
    logic                tail_free;
    logic [AGE_BITS-1:0] tail_age;
    logic                cell_free [NUM_FRAMES];
    logic [AGE_BITS-1:0] cell_age  [NUM_FRAMES];

    assign o_cfg_ready = 1'b1;

    pfr_ctrl #(
        .NUM_FRAMES (NUM_FRAMES),
        .AGE_BITS   (AGE_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .o_busy      (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_shift     (shift),
        .i_head_free (cell_free[0]),
        .i_head_age  (cell_age[0]),
        .o_tail_free (tail_free),
        .o_tail_age  (tail_age)
    );

    // cell k takes from cell k+1; the last cell takes the updated head entry
    for (genvar gi = 0; gi < NUM_FRAMES; gi++) begin : g_ring
        if (gi == NUM_FRAMES - 1) begin : g_tail
            pfr_cell #(
                .AGE_BITS (AGE_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_free  (tail_free),
                .i_age   (tail_age),
                .o_free  (cell_free[gi]),
                .o_age   (cell_age[gi])
            );
        end else begin : g_body
            pfr_cell #(
                .AGE_BITS (AGE_BITS)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_free  (cell_free[gi+1]),
                .i_age   (cell_age[gi+1]),
                .o_free  (cell_free[gi]),
                .o_age   (cell_age[gi])
            );
        end
    end

endmodule

`default_nettype wire

// ===== design/pfr_cell.sv =====
`default_nettype none

module pfr_cell #(
    parameter int AGE_BITS = pfr_pkg::AGE_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_shift,
    input  wire logic                i_free,
    input  wire logic [AGE_BITS-1:0] i_age,
    output logic                     o_free,
    output logic [AGE_BITS-1:0]      o_age
);

    logic                r_free;
    logic [AGE_BITS-1:0] r_age;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free <= 1'b1;
            r_age  <= '0;
        end else if (i_shift) begin
            r_free <= i_free;
            r_age  <= i_age;
        end
    end

    assign o_free = r_free;
    assign o_age  = r_age;

endmodule

`default_nettype wire

// ===== design/pfr_ctrl.sv =====
`default_nettype none

module pfr_ctrl #(
    parameter int NUM_FRAMES = pfr_pkg::NUM_FRAMES_DEF,
    parameter int AGE_BITS   = pfr_pkg::AGE_BITS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_start,
    output logic                                    o_busy,
    input  wire pfr_pkg::t_req                      i_req,
    output logic                                    o_done,
    output pfr_pkg::t_res                           o_res,
    input  wire logic                               i_cfg_valid,
    input  wire logic [pfr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [pfr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                    o_shift,
    input  wire logic                               i_head_free,
    input  wire logic [AGE_BITS-1:0]                i_head_age,
    output logic                                    o_tail_free,
    output logic [AGE_BITS-1:0]                     o_tail_age
);

    localparam int FIDX_W = $clog2(NUM_FRAMES);
    localparam int NF_W   = $clog2(NUM_FRAMES + 1);
    localparam int CMP_W  = (NF_W > pfr_pkg::HAND_W) ? NF_W : pfr_pkg::HAND_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_PASS1,
        S_PASS2
    } t_state;

    t_state                          r_state;
    logic [FIDX_W-1:0]               r_pos;
    logic                            r_lru_cfg;
    logic [pfr_pkg::CFG_DATA_W-1:0]  r_frames_cfg;
    logic                            r_lru;
    logic [pfr_pkg::REQ_W-1:0]       r_op;
    logic [pfr_pkg::FRAME_W-1:0]     r_f;
    logic                            r_fok;
    logic [CMP_W-1:0]                r_n;
    logic [pfr_pkg::HAND_W-1:0]      r_hand;
    logic                            r_found;
    logic [pfr_pkg::FRAME_W-1:0]     r_res;
    logic [AGE_BITS-1:0]             r_top;
    logic                            r_done;
    pfr_pkg::t_res                   r_out;

    logic [CMP_W-1:0]                n_count;
    logic                            n_fok;
    logic                            accept;
    logic [CMP_W-1:0]                pos_ext;
    logic                            in_rng;
    logic                            hit;
    logic                            take_free;
    logic                            take_clk;
    logic                            take_max;
    logic                            last;
    logic                            found_now;
    logic [pfr_pkg::FRAME_W-1:0]     res_now;
    pfr_pkg::t_res                   n_out;

    assign accept = i_start && (r_state == S_IDLE);

    // managed frame count: zero reads as one, capped by table size and index range
    always_comb begin
        n_count = CMP_W'(r_frames_cfg);
        if (n_count == '0) begin
            n_count = CMP_W'(1);
        end
        if (n_count > CMP_W'(NUM_FRAMES)) begin
            n_count = CMP_W'(NUM_FRAMES);
        end
        if (n_count > CMP_W'(pfr_pkg::ADDR_LIMIT)) begin
            n_count = CMP_W'(pfr_pkg::ADDR_LIMIT);
        end
        n_fok = CMP_W'(i_req.frame_index) < n_count;
    end

    // head of the ring: frame r_pos passes through here and re-enters at the tail
    always_comb begin
        pos_ext     = CMP_W'(r_pos);
        in_rng      = pos_ext < r_n;
        hit         = in_rng && (pos_ext == CMP_W'(r_f));
        o_tail_free = i_head_free;
        o_tail_age  = i_head_age;
        take_free   = 1'b0;
        take_clk    = 1'b0;
        take_max    = 1'b0;
        unique case (r_op)
            pfr_pkg::REQ_TOUCH: begin
                if (r_lru) begin
                    if (hit) begin
                        o_tail_age = '0;
                    end else if (r_fok && in_rng && !i_head_free &&
                                 (i_head_age != '1)) begin
                        o_tail_age = i_head_age + 1'b1;
                    end
                end else if (hit) begin
                    o_tail_age = AGE_BITS'(1);
                end
            end
            pfr_pkg::REQ_MARK_OCC,
            pfr_pkg::REQ_MARK_FREE: begin
                if (hit) begin
                    o_tail_free = (r_op == pfr_pkg::REQ_MARK_FREE);
                end
            end
            pfr_pkg::REQ_FIND_FREE: begin
                take_free = !r_found && in_rng && i_head_free;
            end
            pfr_pkg::REQ_VICTIM: begin
                if (r_lru) begin
                    take_max = in_rng && ((r_pos == '0) || (i_head_age > r_top));
                end else if (in_rng && !r_found &&
                             ((r_state == S_PASS2) || (pos_ext >= CMP_W'(r_hand)))) begin
                    // second chance: stop at a clear bit, clear set ones on the way
                    if (i_head_age == '0) begin
                        take_clk = 1'b1;
                    end else begin
                        o_tail_age = '0;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign last      = (r_pos == FIDX_W'(NUM_FRAMES - 1));
    assign found_now = r_found || take_free || take_clk;
    assign res_now   = (take_free || take_clk || take_max) ? pos_ext[pfr_pkg::FRAME_W-1:0]
                                                           : r_res;

    always_comb begin
        unique case (r_op)
            pfr_pkg::REQ_TOUCH,
            pfr_pkg::REQ_MARK_OCC,
            pfr_pkg::REQ_MARK_FREE: begin
                n_out.result_frame = r_f;
                n_out.found        = r_fok;
            end
            pfr_pkg::REQ_FIND_FREE: begin
                n_out.result_frame = found_now ? res_now : '0;
                n_out.found        = found_now;
            end
            pfr_pkg::REQ_VICTIM: begin
                n_out.result_frame = res_now;
                n_out.found        = 1'b1;
            end
            default: begin
                n_out.result_frame = r_f;
                n_out.found        = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_pos        <= '0;
            r_lru_cfg    <= 1'b0;
            r_frames_cfg <= pfr_pkg::FRAMES_RESET;
            r_hand       <= '0;
            r_done       <= 1'b0;
            r_out        <= '0;
            r_lru        <= 1'b0;
            r_op         <= pfr_pkg::REQ_TOUCH;
            r_f          <= '0;
            r_fok        <= 1'b0;
            r_n          <= CMP_W'(1);
            r_found      <= 1'b0;
            r_res        <= '0;
            r_top        <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    pfr_pkg::CFG_POLICY_MODE:   r_lru_cfg    <= i_cfg_data[0];
                    pfr_pkg::CFG_FRAMES_IN_USE: r_frames_cfg <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_PASS1;
                        r_pos   <= '0;
                        r_lru   <= r_lru_cfg;
                        r_op    <= i_req.req_type;
                        r_f     <= i_req.frame_index;
                        r_fok   <= n_fok;
                        r_n     <= n_count;
                        r_found <= 1'b0;
                        r_res   <= '0;
                        r_top   <= '0;
                        if (!r_lru_cfg && (CMP_W'(r_hand) >= n_count)) begin
                            if ((i_req.req_type == pfr_pkg::REQ_VICTIM) ||
                                ((i_req.req_type == pfr_pkg::REQ_TOUCH) && n_fok)) begin
                                r_hand <= '0;
                            end
                        end else if (!r_lru_cfg && n_fok &&
                                     (i_req.req_type == pfr_pkg::REQ_TOUCH)) begin
                            r_hand <= r_hand + 1'b1;
                        end
                    end
                end
                S_PASS1,
                S_PASS2: begin
                    r_pos <= last ? '0 : r_pos + 1'b1;
                    if (take_free || take_clk) begin
                        r_found <= 1'b1;
                        r_res   <= pos_ext[pfr_pkg::FRAME_W-1:0];
                    end
                    if (take_clk) begin
                        r_hand <= pos_ext[pfr_pkg::HAND_W-1:0];
                    end
                    if (take_max) begin
                        r_top <= i_head_age;
                        r_res <= pos_ext[pfr_pkg::FRAME_W-1:0];
                    end
                    if (last) begin
                        if ((r_state == S_PASS1) && (r_op == pfr_pkg::REQ_VICTIM) &&
                            !r_lru && !found_now) begin
                            r_state <= S_PASS2;
                        end else begin
                            r_state <= S_IDLE;
                            r_done  <= 1'b1;
                            r_out   <= n_out;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_shift = (r_state != S_IDLE);
    assign o_done  = r_done;
    assign o_res   = r_out;

    a_done_ends_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_state != S_IDLE))
        else $error("result strobe without a preceding pass");

    a_ring_aligned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (r_pos == '0))
        else $error("ring not back in place when idle");

    a_hand_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hand <= pfr_pkg::HAND_W'(pfr_pkg::ADDR_LIMIT))
        else $error("clock hand out of range");

    a_pass2_clock_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PASS2) |-> ((r_op == pfr_pkg::REQ_VICTIM) && !r_lru))
        else $error("second pass outside a clock victim scan");

    a_pass2_finds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_PASS2) && last) |-> found_now)
        else $error("clock victim scan ended without a victim");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam bit POLICY_CLOCK = 1'b0;
    localparam bit POLICY_LRU   = 1'b1;
    localparam int unsigned AGE_MAX = (1 << pfr_pkg::AGE_BITS_DEF) - 1;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int NUM_PHASES      = 8;
    localparam int DRAIN_CYCLES    = 2 * pfr_pkg::NUM_FRAMES_DEF + 64;
    localparam longint CYCLE_LIMIT = 4000000;

    // frame table shadow: free flags, ages or reference bits, clock hand
    class frame_table_tracker;
        bit                               lru_mode;
        logic [pfr_pkg::CFG_DATA_W-1:0]   frames_reg;
        bit                               free_flag [pfr_pkg::NUM_FRAMES_DEF];
        int unsigned                      use_val [pfr_pkg::NUM_FRAMES_DEF];
        int unsigned                      hand;
        pfr_pkg::t_res                    pending_results [$];
        int                               mismatch_count;

        function new();
            lru_mode       = POLICY_CLOCK;
            frames_reg     = pfr_pkg::FRAMES_RESET;
            hand           = 0;
            mismatch_count = 0;
            foreach (free_flag[i]) begin
                free_flag[i] = 1'b1;
                use_val[i]   = 0;
            end
        endfunction

        function int unsigned live_frames();
            int unsigned n;
            n = 32'(frames_reg);
            if (n == 0) n = 1;
            if (n > pfr_pkg::NUM_FRAMES_DEF) n = pfr_pkg::NUM_FRAMES_DEF;
            if (n > pfr_pkg::ADDR_LIMIT) n = pfr_pkg::ADDR_LIMIT;
            return n;
        endfunction

        function void set_reg(logic [pfr_pkg::CFG_IDX_W-1:0] idx,
                              logic [pfr_pkg::CFG_DATA_W-1:0] val);
            if (idx == pfr_pkg::CFG_POLICY_MODE) lru_mode = val[0];
            else if (idx == pfr_pkg::CFG_FRAMES_IN_USE) frames_reg = val;
        endfunction

        function void touch_frame(int unsigned f, int unsigned n);
            if (lru_mode == POLICY_LRU) begin
                for (int unsigned i = 0; i < n; i++) begin
                    if (!free_flag[i] && use_val[i] < AGE_MAX) use_val[i]++;
                end
                use_val[f] = 0;
            end else begin
                use_val[f] = 1;
                if (hand >= n) hand = 0;
                else hand++;
            end
        endfunction

        function int unsigned choose_victim(int unsigned n);
            int unsigned best;
            int unsigned top;
            best = 0;
            top  = use_val[0];
            if (lru_mode == POLICY_LRU) begin
                for (int unsigned i = 1; i < n; i++) begin
                    if (use_val[i] > top) begin
                        top  = use_val[i];
                        best = i;
                    end
                end
                return best;
            end
            if (hand >= n) hand = 0;
            // second chance: clear set bits until a clear one is met
            for (int unsigned i = 0; i <= 2 * n; i++) begin
                if (use_val[hand] == 0) break;
                use_val[hand] = 0;
                hand++;
                if (hand >= n) hand = 0;
            end
            return hand;
        endfunction

        function void note_request(pfr_pkg::t_req r);
            int unsigned   n;
            int unsigned   f;
            int unsigned   res;
            bit            ok;
            pfr_pkg::t_res want;
            n   = live_frames();
            f   = 32'(r.frame_index);
            res = f;
            ok  = 1'b0;
            case (r.req_type)
                pfr_pkg::REQ_TOUCH, pfr_pkg::REQ_MARK_OCC, pfr_pkg::REQ_MARK_FREE: begin
                    if (f < n) begin
                        if (r.req_type == pfr_pkg::REQ_TOUCH) touch_frame(f, n);
                        else free_flag[f] = (r.req_type == pfr_pkg::REQ_MARK_FREE);
                        ok = 1'b1;
                    end
                end
                pfr_pkg::REQ_FIND_FREE: begin
                    res = 0;
                    for (int unsigned i = 0; i < n; i++) begin
                        if (free_flag[i]) begin
                            res = i;
                            ok  = 1'b1;
                            break;
                        end
                    end
                end
                pfr_pkg::REQ_VICTIM: begin
                    res = choose_victim(n);
                    ok  = 1'b1;
                end
                default: ;
            endcase
            want.result_frame = res[pfr_pkg::FRAME_W-1:0];
            want.found        = ok;
            pending_results.push_back(want);
        endfunction

        function void check_result(pfr_pkg::t_res got);
            pfr_pkg::t_res want;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: frame %0d found %0d", $time,
                         got.result_frame, got.found);
                mismatch_count++;
                return;
            end
            want = pending_results.pop_front();
            if (got.result_frame !== want.result_frame) begin
                $display("%0t: result_frame mismatch: expected %0d, actual %0d", $time,
                         want.result_frame, got.result_frame);
                mismatch_count++;
            end
            if (got.found !== want.found) begin
                $display("%0t: found mismatch: expected %0d, actual %0d", $time,
                         want.found, got.found);
                mismatch_count++;
            end
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            start;
    logic                            busy;
    pfr_pkg::t_req                   i_req;
    logic                            o_done;
    pfr_pkg::t_res                   o_res;
    logic                            i_cfg_valid;
    logic                            o_cfg_ready;
    logic [pfr_pkg::CFG_IDX_W-1:0]   i_cfg_index;
    logic [pfr_pkg::CFG_DATA_W-1:0]  i_cfg_data;

    frame_table_tracker frame_table = new();
    longint cycle_count = 0;
    int idle_pct = 25;

    page_frame_replacement_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_req       (i_req),
        .o_done      (o_done),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) frame_table.check_result(o_res);
    end

    // all tasks start and end on a falling edge
    task automatic hold_off(int cycles);
        start <= 1'b0;
        repeat (cycles) @(negedge i_clk);
    endtask

    task automatic maybe_idle();
        if ($urandom_range(0, 99) < idle_pct) hold_off($urandom_range(1, 300));
    endtask

    task automatic send_req(logic [pfr_pkg::REQ_W-1:0] kind,
                            logic [pfr_pkg::FRAME_W-1:0] idx);
        pfr_pkg::t_req r;
        r.req_type    = kind;
        r.frame_index = idx;
        start <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        frame_table.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [pfr_pkg::CFG_IDX_W-1:0] idx,
                             logic [pfr_pkg::CFG_DATA_W-1:0] val);
        start <= 1'b0;
        while (frame_table.outstanding() != 0) @(negedge i_clk);
        if ($urandom_range(0, 99) < idle_pct) repeat ($urandom_range(1, 8)) @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        frame_table.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [pfr_pkg::FRAME_W-1:0] pick_index(int unsigned n);
        if ($urandom_range(0, 99) < 85) return pfr_pkg::FRAME_W'($urandom_range(0, n - 1));
        return pfr_pkg::FRAME_W'($urandom_range(0, (1 << pfr_pkg::FRAME_W) - 1));
    endfunction

    task automatic send_random_item();
        int unsigned n;
        int unsigned roll;
        n    = frame_table.live_frames();
        roll = $urandom_range(0, 99);
        if (roll < 30) send_req(pfr_pkg::REQ_TOUCH, pick_index(n));
        else if (roll < 44) send_req(pfr_pkg::REQ_FIND_FREE, pick_index(n));
        else if (roll < 60) send_req(pfr_pkg::REQ_VICTIM, pick_index(n));
        else if (roll < 78) send_req(pfr_pkg::REQ_MARK_OCC, pick_index(n));
        else if (roll < 95) send_req(pfr_pkg::REQ_MARK_FREE, pick_index(n));
        else send_req(pfr_pkg::REQ_MARK_FREE + pfr_pkg::REQ_W'($urandom_range(1, 3)),
                      pick_index(n));
    endtask

    task automatic set_phase(int phase);
        logic [pfr_pkg::CFG_DATA_W-1:0] frames;
        bit mode;
        case (phase)
            0: begin mode = POLICY_LRU;   frames = pfr_pkg::FRAMES_RESET; end
            1: begin mode = POLICY_CLOCK; frames = pfr_pkg::FRAMES_RESET; end
            2: begin mode = POLICY_LRU;   frames = pfr_pkg::CFG_DATA_W'(1); end
            3: begin
                mode   = POLICY_CLOCK;
                frames = pfr_pkg::CFG_DATA_W'($urandom_range(2, 16));
            end
            4: begin
                mode   = POLICY_LRU;
                frames = pfr_pkg::CFG_DATA_W'($urandom_range(2, 16));
            end
            5: begin mode = POLICY_CLOCK; frames = '1; end
            6: begin
                mode   = 1'($urandom_range(0, 1));
                frames = pfr_pkg::CFG_DATA_W'($urandom_range(0, 511));
            end
            default: begin
                mode   = 1'($urandom_range(0, 1));
                frames = pfr_pkg::CFG_DATA_W'($urandom_range(2, 8));
            end
        endcase
        write_reg(pfr_pkg::CFG_POLICY_MODE, pfr_pkg::CFG_DATA_W'(mode));
        write_reg(pfr_pkg::CFG_FRAMES_IN_USE, frames);
    endtask

    initial begin
        start       = 1'b0;
        i_req       = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_rst_n     = 1'b0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset config, clock mode over all frames
        send_req(pfr_pkg::REQ_FIND_FREE, 8'd0);
        send_req(pfr_pkg::REQ_TOUCH, 8'd0);
        send_req(pfr_pkg::REQ_TOUCH, 8'd255);
        send_req(pfr_pkg::REQ_VICTIM, 8'd255);
        send_req(pfr_pkg::REQ_MARK_OCC, 8'd255);
        send_req(pfr_pkg::REQ_MARK_FREE, 8'd255);
        send_req(pfr_pkg::REQ_MARK_FREE + 3'd1, 8'd255);
        send_req(pfr_pkg::REQ_MARK_FREE + 3'd3, 8'd0);

        // three frames: out of range, table full, every reference bit set
        write_reg(pfr_pkg::CFG_FRAMES_IN_USE, 9'd3);
        send_req(pfr_pkg::REQ_TOUCH, 8'd200);
        send_req(pfr_pkg::REQ_MARK_OCC, 8'd3);
        send_req(pfr_pkg::REQ_MARK_OCC, 8'd0);
        send_req(pfr_pkg::REQ_MARK_OCC, 8'd1);
        send_req(pfr_pkg::REQ_MARK_OCC, 8'd2);
        send_req(pfr_pkg::REQ_FIND_FREE, 8'd0);
        send_req(pfr_pkg::REQ_TOUCH, 8'd0);
        send_req(pfr_pkg::REQ_TOUCH, 8'd1);
        send_req(pfr_pkg::REQ_TOUCH, 8'd2);
        send_req(pfr_pkg::REQ_VICTIM, 8'd0);

        // LRU with an oversized frame count, then a zero frame count
        write_reg(pfr_pkg::CFG_POLICY_MODE, pfr_pkg::CFG_DATA_W'(POLICY_LRU));
        write_reg(pfr_pkg::CFG_FRAMES_IN_USE, 9'd511);
        send_req(pfr_pkg::REQ_TOUCH, 8'd1);
        send_req(pfr_pkg::REQ_TOUCH, 8'd0);
        send_req(pfr_pkg::REQ_VICTIM, 8'd0);
        send_req(pfr_pkg::REQ_MARK_FREE, 8'd2);
        write_reg(pfr_pkg::CFG_FRAMES_IN_USE, 9'd0);
        send_req(pfr_pkg::REQ_TOUCH, 8'd0);
        send_req(pfr_pkg::REQ_VICTIM, 8'd7);
        send_req(pfr_pkg::REQ_FIND_FREE, 8'd0);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            set_phase(phase);
            idle_pct = (phase == 3) ? 0 : 25;
            for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
                maybe_idle();
                send_random_item();
            end
        end

        start <= 1'b0;
        while (frame_table.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (frame_table.mismatch_count == 0 && frame_table.outstanding() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
